// ----- hw/rtl/lrg_pkg.sv -----
package lrg_pkg;

   localparam int unsigned FRAC_W  = 15;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned SPAN_W  = WORD_W + 1;
   localparam int unsigned PROD_W  = FRAC_W + SPAN_W;

   localparam logic [WORD_W-1:0] LCG_MUL  = 32'd1103515245;
   localparam logic [WORD_W-1:0] LCG_INC  = 32'd12345;
   localparam logic [FRAC_W-1:0] DRAW_DIV = 15'd32767;

   typedef enum logic [1:0] {
      MODE_SEED     = 2'd0,
      MODE_FRACTION = 2'd1,
      MODE_UPPER    = 2'd2,
      MODE_RANGE    = 2'd3
   } lrg_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_SCALE,
      ST_DIVIDE
   } lrg_state_type;

   typedef struct packed {
      logic load;
      logic ack;
   } lrg_div_ctl_type;

endpackage

// ----- hw/rtl/lrg_fold_div.sv -----
// Divide by 2^15-1 through repeated folding: P = H*2^15 + L = H*32767 + (H + L).
module lrg_fold_div (
   input  logic                       clock,
   input  logic                       reset,
   input  lrg_pkg::lrg_div_ctl_type   ctl,
   input  logic [lrg_pkg::PROD_W-1:0] dividend,
   output logic                       done,
   output logic [lrg_pkg::WORD_W-1:0] quotient
);
   import lrg_pkg::*;

   localparam int unsigned HIGH_W = PROD_W - FRAC_W;

   logic                busy_ff, busy_in;
   logic [PROD_W-1:0]   rem_ff, rem_in;
   logic [HIGH_W-1:0]   quo_ff, quo_in;
   logic [HIGH_W-1:0]   high;
   logic [HIGH_W-1:0]   quo_final;

   assign high = rem_ff[PROD_W-1:FRAC_W];
   assign done = busy_ff && (high == '0);

   // a residue of exactly the divisor is one more whole quotient
   assign quo_final = quo_ff + HIGH_W'(rem_ff[FRAC_W-1:0] == DRAW_DIV);
   assign quotient  = quo_final[WORD_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctl.load) begin
         busy_in = 1'b1;
         rem_in  = dividend;
         quo_in  = '0;
      end else if (ctl.ack) begin
         busy_in = 1'b0;
      end else if (busy_ff && (high != '0)) begin
         quo_in = quo_ff + high;
         rem_in = PROD_W'(high) + PROD_W'(rem_ff[FRAC_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// ----- hw/rtl/lcg_random_range_generator.sv -----
// A fraction, upper or range word runs the generator multiply, then the scale multiply,
// then the folding passes of the divider; rsp_valid rises once the result is ready and
// the response register is free, so a held response waits on rsp_ready. Seed words
// only advance the generator and give no response. The single shared 33x32 multiplier
// and the fold adder of the divider serve one word at a time; new words wait for idle.
// Reset clears the generator state to zero and drops any pending response.
module lcg_random_range_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [lrg_pkg::WORD_W-1:0]        req_seed_value,
   input  logic signed [lrg_pkg::WORD_W-1:0] req_lower,
   input  logic signed [lrg_pkg::WORD_W-1:0] req_upper,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lrg_pkg::FRAC_W-1:0]        rsp_fraction,
   output logic signed [lrg_pkg::WORD_W-1:0] rsp_value,
   output logic                              rsp_error
);
   import lrg_pkg::*;

   // sequencer
   lrg_state_type           fsm_ff, fsm_in;

   // captured request word
   lrg_mode_type            mode_ff, mode_in;
   logic [WORD_W-1:0]       seed_ff, seed_in;
   logic signed [WORD_W-1:0] lower_ff, lower_in;
   logic signed [WORD_W-1:0] upper_ff, upper_in;

   // generator state and drawn numerator
   logic [WORD_W-1:0]       gen_ff, gen_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FRAC_W-1:0]       rsp_frac_ff, rsp_frac_in;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_error_ff, rsp_error_in;

   // shared multiplier
   logic [SPAN_W-1:0]       mul_a;
   logic [WORD_W-1:0]       mul_b;
   logic [SPAN_W+WORD_W-1:0] product;

   logic                    accept;
   logic                    rsp_free;
   logic                    finish;
   logic [FRAC_W-1:0]       draw;
   logic [FRAC_W-1:0]       draw_mod;
   logic [SPAN_W-1:0]       span;
   logic                    empty;
   logic signed [WORD_W-1:0] value;

   lrg_div_ctl_type         div_ctl;
   logic                    div_done;
   logic [WORD_W-1:0]       div_quotient;

   lrg_fold_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (product[PROD_W-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (fsm_ff == ST_DIVIDE) && div_done && rsp_free;

   assign product = (SPAN_W+WORD_W)'(mul_a) * (SPAN_W+WORD_W)'(mul_b);

   // bits 30:16 of the advanced state, folded into 0..32766
   assign draw     = gen_ff[WORD_W-2:WORD_W-1-FRAC_W];
   assign draw_mod = (draw == DRAW_DIV) ? '0 : draw;

   // range span in 33 bits: up to 2^32 when the interval is the whole word
   always_comb begin
      if (mode_ff == MODE_RANGE) begin
         span = {upper_ff[WORD_W-1], upper_ff} - {lower_ff[WORD_W-1], lower_ff}
                + SPAN_W'(1);
      end else begin
         span = {upper_ff[WORD_W-1], upper_ff};
      end
   end

   // pick the empty-interval flag and the offset for the scaled quotient
   always_comb begin
      empty = 1'b0;
      value = '0;
      case (mode_ff) inside
         MODE_SEED, MODE_FRACTION: begin
            empty = 1'b0;
            value = '0;
         end
         MODE_UPPER: begin
            empty = upper_ff[WORD_W-1] || (upper_ff == '0);
            value = empty ? '0 : $signed(div_quotient + WORD_W'(1));
         end
         MODE_RANGE: begin
            empty = lower_ff > upper_ff;
            value = empty ? '0 : $signed(div_quotient + lower_ff);
         end
         default: begin
            empty = 1'b0;
            value = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         ST_IDLE: begin
            if (accept) fsm_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            fsm_in = (mode_ff == MODE_SEED) ? ST_IDLE : ST_SCALE;
         end
         ST_SCALE: begin
            fsm_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (finish) fsm_in = ST_IDLE;
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs: multiplier operands and divider control
   always_comb begin
      req_ready    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_ctl.load = 1'b0;
      div_ctl.ack  = 1'b0;
      unique case (fsm_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_ADVANCE: begin
            mul_a = SPAN_W'((mode_ff == MODE_SEED) ? seed_ff : gen_ff);
            mul_b = LCG_MUL;
         end
         ST_SCALE: begin
            // scale by the numerator of the freshly advanced state
            mul_a        = span;
            mul_b        = WORD_W'(draw_mod);
            div_ctl.load = 1'b1;
         end
         ST_DIVIDE: begin
            div_ctl.ack = finish;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      mode_in      = mode_ff;
      seed_in      = seed_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      gen_in       = gen_ff;
      frac_in      = frac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_frac_in  = rsp_frac_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      // hold the request word for the whole draw
      if (accept) begin
         mode_in  = lrg_mode_type'(req_mode);
         seed_in  = req_seed_value;
         lower_in = req_lower;
         upper_in = req_upper;
      end

      // advance the generator, seeding first when asked
      if (fsm_ff == ST_ADVANCE) begin
         gen_in = product[WORD_W-1:0] + LCG_INC;
      end

      // hold the numerator for the response
      if (fsm_ff == ST_SCALE) begin
         frac_in = draw_mod;
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_frac_in  = frac_ff;
         rsp_value_in = value;
         rsp_error_in = empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      seed_ff      <= seed_in;
      lower_ff     <= lower_in;
      upper_ff     <= upper_in;
      frac_ff      <= frac_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fraction = rsp_frac_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_error    = rsp_error_ff;

endmodule
